// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for the concurrent checks in the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/crc8fr_pkg.sv =====
// ----------------------------------------------------------------------------
// crc8fr_pkg
// Types, constants and the CRC-8 byte update for the SOF/length/CRC-8 deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package crc8fr_pkg;

    localparam int DEF_MAX_PAYLOAD = 32;
    localparam int HEADER_BYTES    = 4;
    localparam int PADDR_W         = 5;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    // Register reset values
    localparam logic [7:0] RST_SOF_BYTE  = 8'hAA;
    localparam logic [7:0] RST_FIRST_ID  = 8'h01;
    localparam logic [7:0] RST_SECOND_ID = 8'h02;
    localparam logic [5:0] RST_MIN_LEN   = 6'd1;
    localparam logic [5:0] RST_MAX_LEN   = 6'd32;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_SOF_BYTE  = 3'd0;
    localparam logic [2:0] REG_FIRST_ID  = 3'd1;
    localparam logic [2:0] REG_SECOND_ID = 3'd2;
    localparam logic [2:0] REG_MIN_LEN   = 3'd3;
    localparam logic [2:0] REG_MAX_LEN   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_REFEED_RD,
        ST_REFEED_DO
    } state_t;

    typedef enum logic [1:0] {
        FEED_NONE,
        FEED_PASS,
        FEED_FAIL
    } feed_evt_t;

    // CRC-8/ATM update with one byte, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] v);
        logic [7:0] c;
        c = crc ^ v;
        for (int b = 0; b < 8; b++)
        begin
            if ((c & CRC_TOP) != 8'h00)
            begin
                c = (c << 1) ^ CRC_POLY;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/crc8_frame_parser_resync.sv =====
// Throughput: one input byte per cycle while no frame completes; in_ready stays high.
// A byte that ends a good frame holds input while the frame streams out, each byte as a
//   store read, then an output register load, plus any output stalls.
// CRC failure: store entries are read and checked for SOF; from one found, each byte is
//   read from the store and re-parsed, with any frame found streamed out as above.
// Reset: the parser hunts for SOF, registers take reset values; the store is never cleared.
// ----------------------------------------------------------------------------
// crc8_frame_parser_resync
// SOF/source/length/payload/CRC-8 deframer with in-candidate resync on CRC error.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module crc8_frame_parser_resync #(
    parameter int MAX_PAYLOAD = crc8fr_pkg::DEF_MAX_PAYLOAD
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     in_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     frame_byte,
    output logic                           last_of_frame,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [crc8fr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import crc8fr_pkg::*;

    localparam int DEPTH = HEADER_BYTES + MAX_PAYLOAD + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    // Configuration registers
    logic [7:0] sof_byte_reg;
    logic [7:0] first_id_reg;
    logic [7:0] second_id_reg;
    logic [5:0] min_len_reg;
    logic [5:0] max_len_reg;
    logic [2:0] reg_idx;

    // Candidate store
    logic [7:0]    mem [DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    rdata_reg;

    // Parser and sequencer state
    state_t        state_reg, state_next;
    logic [CW-1:0] bc_reg, bc_next;
    logic [CW-1:0] flen_reg, flen_next;
    logic [7:0]    len_hi_reg, len_hi_next;
    logic [7:0]    crc_reg, crc_next;
    logic [AW-1:0] src_reg, src_next;
    logic [CW-1:0] total_reg, total_next;
    logic [AW-1:0] emit_idx_reg, emit_idx_next;
    logic [AW-1:0] emit_end_reg, emit_end_next;
    logic          resume_reg, resume_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    frame_byte_reg, frame_byte_next;
    logic          last_reg, last_next;

    // Parser step outputs
    logic [7:0]    feed_byte;
    logic          feed_go;
    feed_evt_t     f_evt;
    logic [CW-1:0] f_bc;
    logic [CW-1:0] f_flen;
    logic [7:0]    f_hi;
    logic [7:0]    f_crc;
    logic          f_we;
    logic [AW-1:0] f_waddr;
    logic [7:0]    crc_upd;
    logic [15:0]   len16;
    logic          len_bad;
    logic [CW-1:0] bc_inc;
    logic          more;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sof_byte_reg  <= RST_SOF_BYTE;
            first_id_reg  <= RST_FIRST_ID;
            second_id_reg <= RST_SECOND_ID;
            min_len_reg   <= RST_MIN_LEN;
            max_len_reg   <= RST_MAX_LEN;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_idx)
                REG_SOF_BYTE:  sof_byte_reg  <= pwdata[7:0];
                REG_FIRST_ID:  first_id_reg  <= pwdata[7:0];
                REG_SECOND_ID: second_id_reg <= pwdata[7:0];
                REG_MIN_LEN:   min_len_reg   <= pwdata[5:0];
                REG_MAX_LEN:   max_len_reg   <= pwdata[5:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SOF_BYTE:  prdata = {24'd0, sof_byte_reg};
            REG_FIRST_ID:  prdata = {24'd0, first_id_reg};
            REG_SECOND_ID: prdata = {24'd0, second_id_reg};
            REG_MIN_LEN:   prdata = {26'd0, min_len_reg};
            REG_MAX_LEN:   prdata = {26'd0, max_len_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Candidate store: one write and one registered read per cycle.
    // Re-parse writes land below the read pointer, so they never clobber
    // bytes still to be read; the sequencer keeps reads and writes in
    // separate cycles otherwise.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Parser step: one byte against the current candidate
    // ------------------------------------------------------------------
    assign feed_byte = (state_reg == ST_REFEED_DO) ? rdata_reg : in_byte;
    assign crc_upd   = crc8_step(crc_reg, feed_byte);
    assign len16     = {len_hi_reg, feed_byte};
    assign bc_inc    = bc_reg + CW'(1);
    assign len_bad   = (len16 == 16'd0) || (len16 < {10'd0, min_len_reg})
                     || (len16 > {10'd0, max_len_reg}) || (len16 > 16'(MAX_PAYLOAD));

    always_comb
    begin
        f_evt   = FEED_NONE;
        f_bc    = bc_reg;
        f_flen  = flen_reg;
        f_hi    = len_hi_reg;
        f_crc   = crc_reg;
        f_we    = 1'b1;
        f_waddr = bc_reg[AW-1:0];

        priority if (bc_reg == CW'(0))
        begin
            f_waddr = '0;
            if (feed_byte == sof_byte_reg)
            begin
                f_bc  = CW'(1);
                f_crc = 8'h00;
            end
            else
            begin
                f_we = 1'b0;
            end
        end
        else if ((bc_reg == CW'(1) &&
                  feed_byte != first_id_reg && feed_byte != second_id_reg) ||
                 (bc_reg == CW'(3) && len_bad))
        begin
            // drop; reuse the byte as a new start if it is SOF
            f_flen  = '0;
            f_crc   = 8'h00;
            f_waddr = '0;
            if (feed_byte == sof_byte_reg)
            begin
                f_bc = CW'(1);
            end
            else
            begin
                f_bc = '0;
                f_we = 1'b0;
            end
        end
        else if (bc_reg == CW'(1) || bc_reg == CW'(2))
        begin
            f_bc  = bc_inc;
            f_crc = crc_upd;
            f_hi  = feed_byte;
        end
        else if (bc_reg == CW'(3))
        begin
            f_bc   = bc_inc;
            f_crc  = crc_upd;
            f_flen = len16[CW-1:0] + CW'(HEADER_BYTES + 1);
        end
        else if (bc_reg >= CW'(DEPTH))
        begin
            f_we   = 1'b0;
            f_bc   = '0;
            f_flen = '0;
            f_crc  = 8'h00;
        end
        else if (bc_inc < flen_reg)
        begin
            f_bc  = bc_inc;
            f_crc = crc_upd;
        end
        else
        begin
            // last byte of the frame: compare against the running CRC
            f_evt  = (crc_reg == feed_byte) ? FEED_PASS : FEED_FAIL;
            f_bc   = '0;
            f_flen = '0;
            f_crc  = 8'h00;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign in_ready = (state_reg == ST_IDLE);
    assign feed_go  = (in_valid && in_ready) || (state_reg == ST_REFEED_DO);
    assign more     = (CW'(src_reg) + CW'(1)) < total_reg;

    assign mem_we    = feed_go && f_we;
    assign mem_waddr = f_waddr;
    assign mem_wdata = feed_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bc_reg        <= '0;
            flen_reg      <= '0;
            crc_reg       <= 8'h00;
            src_reg       <= '0;
            total_reg     <= '0;
            emit_idx_reg  <= '0;
            emit_end_reg  <= '0;
            resume_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bc_reg        <= bc_next;
            flen_reg      <= flen_next;
            crc_reg       <= crc_next;
            src_reg       <= src_next;
            total_reg     <= total_next;
            emit_idx_reg  <= emit_idx_next;
            emit_end_reg  <= emit_end_next;
            resume_reg    <= resume_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_hi_reg     <= len_hi_next;
        frame_byte_reg <= frame_byte_next;
        last_reg       <= last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        bc_next         = bc_reg;
        flen_next       = flen_reg;
        len_hi_next     = len_hi_reg;
        crc_next        = crc_reg;
        src_next        = src_reg;
        total_next      = total_reg;
        emit_idx_next   = emit_idx_reg;
        emit_end_next   = emit_end_reg;
        resume_next     = resume_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        frame_byte_next = frame_byte_reg;
        last_next       = last_reg;
        mem_re          = 1'b0;
        mem_raddr       = src_reg;

        if (feed_go)
        begin
            bc_next     = f_bc;
            flen_next   = f_flen;
            len_hi_next = f_hi;
            crc_next    = f_crc;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (feed_go)
                begin
                    unique case (f_evt)
                        FEED_PASS:
                        begin
                            emit_idx_next = '0;
                            emit_end_next = bc_reg[AW-1:0];
                            resume_next   = 1'b0;
                            state_next    = ST_EMIT_RD;
                        end
                        FEED_FAIL:
                        begin
                            total_next = flen_reg;
                            src_next   = AW'(1);
                            state_next = ST_SCAN_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_EMIT_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = emit_idx_reg;
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    frame_byte_next = rdata_reg;
                    last_next       = (emit_idx_reg == emit_end_reg);
                    if (emit_idx_reg == emit_end_reg)
                    begin
                        state_next = resume_reg ? ST_REFEED_RD : ST_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + AW'(1);
                        state_next    = ST_EMIT_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (rdata_reg == sof_byte_reg)
                begin
                    state_next = ST_REFEED_RD;
                end
                else if (more)
                begin
                    src_next   = src_reg + AW'(1);
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REFEED_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_REFEED_DO;
            end
            ST_REFEED_DO:
            begin
                // a failure here only drops the new candidate (already cleared)
                src_next = src_reg + AW'(1);
                if (f_evt == FEED_PASS)
                begin
                    emit_idx_next = '0;
                    emit_end_next = bc_reg[AW-1:0];
                    resume_next   = more;
                    state_next    = ST_EMIT_RD;
                end
                else
                begin
                    state_next = more ? ST_REFEED_RD : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign frame_byte    = frame_byte_reg;
    assign last_of_frame = last_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_bc_in_store, bc_reg < CW'(DEPTH), "byte count beyond candidate store")
    `ASSERT_IMPLIES(a_flen_valid, bc_reg >= CW'(HEADER_BYTES),
        flen_reg > bc_reg && flen_reg <= CW'(DEPTH), "frame length inconsistent with count")
    `ASSERT_IMPLIES(a_rescan_ptr,
        state_reg == ST_SCAN_RD || state_reg == ST_SCAN_CHK ||
        state_reg == ST_REFEED_RD || state_reg == ST_REFEED_DO,
        src_reg != '0 && CW'(src_reg) < total_reg, "resync pointer out of range")
    `ASSERT_IMPLIES(a_emit_ptr, state_reg == ST_EMIT_RD || state_reg == ST_EMIT_OUT,
        emit_idx_reg <= emit_end_reg, "emit pointer past end of frame")

endmodule

`default_nettype wire
